// ===== hw/rtl/ffg_pkg.sv =====
// shared types and constants of the forest fire grid step unit
`timescale 1ns / 1ps

package ffg_pkg;

	// cell codes
	typedef enum logic [1:0] {
		CELL_EMPTY = 2'd0,
		CELL_TREE  = 2'd1,
		CELL_ASH   = 2'd2,
		CELL_FIRE  = 2'd3
	} cell_t;

	// pass modes; the last code passes cells through unchanged
	typedef enum logic [1:0] {
		MODE_BURN   = 2'd0,
		MODE_IGNITE = 2'd1,
		MODE_FILL   = 2'd2,
		MODE_HOLD   = 2'd3
	} mode_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_PASS_MODE  = 2'd0,
		REG_GRID_ROWS  = 2'd1,
		REG_GRID_COLS  = 2'd2,
		REG_TREE_THRES = 2'd3
	} reg_index_t;

	typedef logic [14:0] count_t;

	localparam logic [31:0] GEN_MULT     = 32'd16562261;
	localparam logic [31:0] GEN_SEED     = 32'd661105;
	localparam logic [31:0] THRES_RESET  = 32'd2791728742;
	localparam logic [7:0]  SIZE_RESET   = 8'd100;
	localparam count_t      COUNT_MAX    = 15'd32767;

endpackage

// ===== hw/rtl/ffg_ram.sv =====
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module ffg_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/forest_fire_grid_step_unit.sv =====
// Forest fire grid step: raster stencil over two lines held in a column-wide ram.
// The result for a cell of row r-1 passes from stage 1 into the output register after
// the beat of cell (r,c) is taken, a bottom row second result after it; row 0 gives none.
// Throughput: one cell per cycle while the output is not stalled, set by the single ram read
// and write per column; bottom row cells give two results each, in the one output register.
// Reset: arst_n at once clears control, positions and counters, loads the generator with
// seed times multiplier; the line ram is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module forest_fire_grid_step_unit #(
	parameter int MAX_ROWS = 128,
	parameter int MAX_COLS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	// input cells
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [1:0] cell_state, [7:2] zero
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [1:0] next_state, [16:2] empty_count,
	                               // [31:17] tree_count, [46:32] ash_count,
	                               // [61:47] fire_count, [63:62] zero
	output logic        m_tlast    // frame_last
);

	import ffg_pkg::*;

	localparam int RPW = $clog2(MAX_ROWS);
	localparam int RW  = $clog2(MAX_ROWS + 1);
	localparam int CPW = $clog2(MAX_COLS);
	localparam int CW  = $clog2(MAX_COLS + 1);

	// configuration registers
	mode_t       mode_q;
	logic [7:0]  grid_rows_q;
	logic [7:0]  grid_cols_q;
	logic [31:0] thres_q;

	// raster position of the next beat
	logic [RPW-1:0] row_q;
	logic [CPW-1:0] col_q;

	// generator, holds the value the next fill cell compares
	logic [31:0] gen_q;
	localparam logic [31:0] GEN_FIRST = 32'(64'(GEN_SEED) * 64'(GEN_MULT));

	// stage 1
	logic           valid_s1;
	cell_t          cur_s1;
	logic [CPW-1:0] col_s1;
	logic           bank_s1;
	logic           row0_s1;
	logic           bottom_s1;
	logic           inner_s1;
	logic           ign_s1;
	logic           last_s1;
	logic           clear_s1;
	logic           phase_q;

	// column window
	logic [3:0] cur_w_q;
	cell_t      west_q;
	logic [3:0] rdata;

	// counters
	count_t cnt_q   [4];
	count_t cnt_inc [4];

	// output register
	logic   out_valid_q;
	cell_t  out_state_q;
	logic   out_last_q;
	count_t out_cnt_q [4];

	// clamped grid size
	logic [RW-1:0] rows_eff;
	logic [CW-1:0] cols_eff;

	always_comb begin
		if (grid_rows_q < 8'd3) begin
			rows_eff = RW'(3);
		end else if (32'(grid_rows_q) > 32'(MAX_ROWS)) begin
			rows_eff = RW'(MAX_ROWS);
		end else begin
			rows_eff = RW'(grid_rows_q);
		end
		if (grid_cols_q < 8'd3) begin
			cols_eff = CW'(3);
		end else if (32'(grid_cols_q) > 32'(MAX_COLS)) begin
			cols_eff = CW'(MAX_COLS);
		end else begin
			cols_eff = CW'(grid_cols_q);
		end
	end

	// position of the beat being taken, with next position
	logic [RPW-1:0] r_a;
	logic [CPW-1:0] c_a;
	logic [CW-1:0]  c1;
	logic [RW-1:0]  r1;
	logic           row_end;
	logic           col_lastp;
	logic [CPW-1:0] raddr;

	always_comb begin
		if (RW'(row_q) >= rows_eff || CW'(col_q) >= cols_eff) begin
			r_a = '0;
			c_a = '0;
		end else begin
			r_a = row_q;
			c_a = col_q;
		end
		c1        = CW'(c_a) + CW'(1);
		r1        = RW'(r_a) + RW'(1);
		row_end   = (c1 >= cols_eff);
		col_lastp = (CW'(c_a) == cols_eff - CW'(1));
		raddr     = row_end ? '0 : c1[CPW-1:0];
	end

	// stage 1 handshake
	logic out_free;
	logic give;
	logic s1_done;
	logic accept;

	assign out_free = !out_valid_q || m_tready;
	assign give     = valid_s1 && !row0_s1 && out_free;
	assign s1_done  = valid_s1 && (row0_s1 || (give && (phase_q || !bottom_s1)));
	assign s_tready = !valid_s1 || s1_done;
	assign accept   = s_tvalid && s_tready;

	// neighborhood of the cell in row r-1
	cell_t centre, north, east, res_a, res_b, res;

	always_comb begin
		centre = cell_t'(bank_s1 ? cur_w_q[1:0] : cur_w_q[3:2]);
		north  = cell_t'(bank_s1 ? cur_w_q[3:2] : cur_w_q[1:0]);
		east   = cell_t'(bank_s1 ? rdata[1:0] : rdata[3:2]);
	end

	// next state rules
	always_comb begin
		res_a = centre;
		res_b = cur_s1;
		unique case (mode_q)
			MODE_BURN: begin
				if (inner_s1 && centre == CELL_TREE && (north == CELL_FIRE ||
				    west_q == CELL_FIRE || east == CELL_FIRE || cur_s1 == CELL_FIRE)) begin
					res_a = CELL_FIRE;
				end else if (inner_s1 && centre == CELL_FIRE) begin
					res_a = CELL_ASH;
				end
			end
			MODE_IGNITE: begin
				if (ign_s1 && centre == CELL_TREE) begin
					res_a = CELL_FIRE;
				end
			end
			MODE_FILL: begin
				res_a = (inner_s1 && gen_q < thres_q) ? CELL_TREE : CELL_EMPTY;
				res_b = CELL_EMPTY;
			end
			MODE_HOLD: begin
				res_a = centre;
			end
			default: begin
				res_a = centre;
			end
		endcase
		res = phase_q ? res_b : res_a;
	end

	// saturating count of the result being handed over
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			cnt_inc[k] = cnt_q[k];
			if (res == cell_t'(k) && cnt_q[k] != COUNT_MAX) begin
				cnt_inc[k] = cnt_q[k] + 15'd1;
			end
		end
	end

	// configuration and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_BURN;
			grid_rows_q <= SIZE_RESET;
			grid_cols_q <= SIZE_RESET;
			thres_q     <= THRES_RESET;
			row_q       <= '0;
			col_q       <= '0;
		end else if (cfg_wr_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_PASS_MODE:  mode_q <= mode_t'(cfg_wdata[1:0]);
				REG_GRID_ROWS: begin
					grid_rows_q <= cfg_wdata[7:0];
					row_q       <= '0;
					col_q       <= '0;
				end
				REG_GRID_COLS: begin
					grid_cols_q <= cfg_wdata[7:0];
					row_q       <= '0;
					col_q       <= '0;
				end
				REG_TREE_THRES: thres_q <= cfg_wdata;
				default: ;
			endcase
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= (r1 >= rows_eff) ? '0 : r1[RPW-1:0];
			end else begin
				col_q <= c1[CPW-1:0];
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
			if (s1_done) begin
				phase_q <= 1'b0;
			end else if (give && bottom_s1) begin
				phase_q <= 1'b1;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1    <= cell_t'(s_tdata[1:0]);
			col_s1    <= c_a;
			bank_s1   <= r_a[0];
			row0_s1   <= (r_a == '0);
			bottom_s1 <= (RW'(r_a) == rows_eff - RW'(1));
			inner_s1  <= (r_a >= RPW'(2)) && (c_a != '0) && !col_lastp;
			ign_s1    <= (r_a == RPW'(2)) && (c_a != '0) && !col_lastp;
			last_s1   <= (RW'(r_a) == rows_eff - RW'(1)) && col_lastp;
			clear_s1  <= (r_a == '0) && (c_a == '0);
		end
	end

	// column window moves on when an item leaves stage 1
	always_ff @(posedge clk) begin
		if (s1_done) begin
			cur_w_q <= rdata;
			west_q  <= centre;
		end
	end

	// line ram: one word per column, two banks for the two lines
	logic [3:0] wdata;
	assign wdata = bank_s1 ? {cur_s1, cur_w_q[1:0]} : {cur_w_q[3:2], cur_s1};

	ffg_ram #(
		.WIDTH (4),
		.DEPTH (MAX_COLS)
	) u_line_ram (
		.clk   (clk),
		.we    (s1_done),
		.waddr (col_s1),
		.wdata (wdata),
		.re    (accept),
		.raddr (raddr),
		.rdata (rdata)
	);

	// generator and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= GEN_FIRST;
			for (int k = 0; k < 4; k++) begin
				cnt_q[k] <= '0;
			end
		end else begin
			if (give && !phase_q && inner_s1 && mode_q == MODE_FILL) begin
				gen_q <= gen_q * GEN_MULT;
			end
			if (s1_done && clear_s1) begin
				for (int k = 0; k < 4; k++) begin
					cnt_q[k] <= '0;
				end
			end else if (give) begin
				cnt_q <= cnt_inc;
			end
		end
	end

	// output register
	logic res_last;
	assign res_last = phase_q && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (give) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (give) begin
			out_state_q <= res;
			out_last_q  <= res_last;
			for (int k = 0; k < 4; k++) begin
				out_cnt_q[k] <= res_last ? cnt_inc[k] : '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {2'b00, out_cnt_q[3], out_cnt_q[2], out_cnt_q[1], out_cnt_q[0],
	                   out_state_q};

`ifndef SYNTH
	// second result only for a bottom row item
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (valid_s1 && bottom_s1 && !row0_s1))
		else $error("second result phase outside a bottom row item");

	// a bottom row item that hands its first result moves to the second
	assert property (@(posedge clk) disable iff (!arst_n)
		(give && !phase_q && bottom_s1) |=> phase_q)
		else $error("bottom row item lost its second result");

	// counts only travel with the frame's last beat
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[61:2] == '0))
		else $error("counts on a beat that is not the frame's last");

	// generator only steps for a handed fill result
	assert property (@(posedge clk) disable iff (!arst_n)
		(gen_q != $past(gen_q)) |-> $past(give && mode_q == MODE_FILL))
		else $error("generator stepped outside a fill result");
`endif

endmodule

// ===== sim/tb_forest_fire_grid_step_unit.sv =====
// testbench of the forest fire grid step unit: random grids streamed in, next generation checked
`timescale 1ns / 1ps

module tb_forest_fire_grid_step_unit;

	import ffg_pkg::*;

	localparam int TB_MAX_ROWS = 128;
	localparam int TB_MAX_COLS = 128;
	localparam int DRAIN_PAD   = 8;
	localparam int RANDOM_CELLS = 1700;

	// one next-generation beat as the unit should send it
	typedef struct packed {
		count_t fire_count;
		count_t ash_count;
		count_t tree_count;
		count_t empty_count;
		logic   frame_last;
		cell_t  next_state;
	} gen_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tlast;

	forest_fire_grid_step_unit #(
		.MAX_ROWS(TB_MAX_ROWS),
		.MAX_COLS(TB_MAX_COLS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	// cells waiting to be sent and next-generation beats still owed
	cell_t     pending_cells [$];
	gen_beat_t expected_next [$];
	int        fail_count = 0;

	// grid model: registers, two kept lines, raster position, generator, tallies
	mode_t       cfg_mode  = MODE_BURN;
	logic [7:0]  cfg_rows  = SIZE_RESET;
	logic [7:0]  cfg_cols  = SIZE_RESET;
	logic [31:0] cfg_thres = THRES_RESET;
	bit [1:0]    kept_lines [2][TB_MAX_COLS];
	int          pos_row = 0;
	int          pos_col = 0;
	logic [31:0] gen_val = GEN_SEED;
	count_t      tally [4] = '{default: '0};

	// idling controls
	bit tx_gaps_on = 1'b0;
	bit rx_stalls_on = 1'b0;
	int tx_burst_left = 0;
	int tx_gap_left = 0;
	int rx_run_left = 0;
	int rx_stall_left = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int clamp_size(logic [7:0] v, int hi);
		if (v < 8'd3) return 3;
		if (int'(v) > hi) return hi;
		return int'(v);
	endfunction

	// new state of one cell; fill mode advances the generator for a non-border cell
	function automatic cell_t evolve_cell(int r, int c, int rows, int cols, cell_t centre,
		cell_t north, cell_t west, cell_t east, cell_t south);
		logic border;
		border = (r == 0) || (r == rows - 1) || (c == 0) || (c == cols - 1);
		case (cfg_mode)
			MODE_BURN: begin
				if (border) return centre;
				if (centre == CELL_TREE && (north == CELL_FIRE || west == CELL_FIRE ||
					east == CELL_FIRE || south == CELL_FIRE)) return CELL_FIRE;
				if (centre == CELL_FIRE) return CELL_ASH;
				return centre;
			end
			MODE_IGNITE: begin
				if (!border && r == 1 && centre == CELL_TREE) return CELL_FIRE;
				return centre;
			end
			MODE_FILL: begin
				if (border) return CELL_EMPTY;
				gen_val = gen_val * GEN_MULT;
				return (gen_val < cfg_thres) ? CELL_TREE : CELL_EMPTY;
			end
			default: return centre;
		endcase
	endfunction

	// tally a new cell and queue its beat; counts ride on the frame's last beat
	task automatic owe_beat(cell_t v, logic last);
		gen_beat_t beat;
		if (tally[v] < COUNT_MAX) tally[v] = tally[v] + 1'b1;
		beat.next_state  = v;
		beat.frame_last  = last;
		beat.empty_count = last ? tally[CELL_EMPTY] : '0;
		beat.tree_count  = last ? tally[CELL_TREE]  : '0;
		beat.ash_count   = last ? tally[CELL_ASH]   : '0;
		beat.fire_count  = last ? tally[CELL_FIRE]  : '0;
		expected_next.push_back(beat);
	endtask

	// one accepted cell: emit row r-1 cell, plus the bottom-row cell itself
	task automatic step_grid_model(cell_t cur);
		int rows, cols, r, c, pl, ol;
		cell_t centre, north, west, east, v;
		rows = clamp_size(cfg_rows, TB_MAX_ROWS);
		cols = clamp_size(cfg_cols, TB_MAX_COLS);
		if (pos_row >= rows || pos_col >= cols) begin
			pos_row = 0;
			pos_col = 0;
		end
		r = pos_row;
		c = pos_col;
		if (r == 0 && c == 0) begin
			for (int k = 0; k < 4; k++) tally[k] = '0;
		end
		if (r >= 1) begin
			pl = (r - 1) % 2;
			ol = r % 2;
			centre = cell_t'(kept_lines[pl][c]);
			north  = cell_t'(kept_lines[ol][c]);
			west   = (c > 0) ? cell_t'(kept_lines[pl][c - 1]) : CELL_EMPTY;
			east   = (c + 1 < cols) ? cell_t'(kept_lines[pl][c + 1]) : CELL_EMPTY;
			v = evolve_cell(r - 1, c, rows, cols, centre, north, west, east, cur);
			owe_beat(v, 1'b0);
			if (r == rows - 1) begin
				v = evolve_cell(r, c, rows, cols, cur, CELL_EMPTY, CELL_EMPTY, CELL_EMPTY,
					CELL_EMPTY);
				owe_beat(v, c == cols - 1);
			end
		end
		kept_lines[r % 2][c] = cur;
		pos_col = c + 1;
		if (pos_col >= cols) begin
			pos_col = 0;
			pos_row = r + 1;
			if (pos_row >= rows) pos_row = 0;
		end
	endtask

	task automatic report_mismatch(string msg);
		if (fail_count < 40) $display("[%0t] MISMATCH %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic check_field(string name, int unsigned got, int unsigned want);
		if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	// compare one result beat with the oldest owed beat
	task automatic check_beat();
		gen_beat_t want;
		if (expected_next.size() == 0) begin
			report_mismatch($sformatf("beat with nothing owed, tdata %h", m_tdata));
		end else begin
			want = expected_next.pop_front();
			check_field("next_state", m_tdata[1:0], want.next_state);
			check_field("frame_last", m_tlast, want.frame_last);
			check_field("empty_count", m_tdata[16:2], want.empty_count);
			check_field("tree_count", m_tdata[31:17], want.tree_count);
			check_field("ash_count", m_tdata[46:32], want.ash_count);
			check_field("fire_count", m_tdata[61:47], want.fire_count);
		end
	endtask

	// driver: bursts of cells with gaps between them
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) step_grid_model(cell_t'(s_tdata[1:0]));
			if (tx_gap_left > 0) begin
				tx_gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_cells.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= {6'd0, pending_cells.pop_front()};
				if (tx_burst_left > 0) begin
					tx_burst_left--;
				end else begin
					tx_burst_left = $urandom_range(0, 15);
					tx_gap_left = tx_gaps_on ? $urandom_range(0, 6) : 0;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: check accepted beats, ready runs broken by stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) check_beat();
			if (rx_run_left > 0) begin
				rx_run_left--;
				m_tready <= 1'b1;
			end else if (rx_stall_left > 0) begin
				rx_stall_left--;
				m_tready <= 1'b0;
			end else begin
				rx_run_left = $urandom_range(0, 10);
				rx_stall_left = rx_stalls_on ? $urandom_range(1, 8) : 0;
				m_tready <= 1'b1;
			end
		end
	end

	// register write, mirrored into the model once it has landed
	task automatic cfg_write(reg_index_t idx, logic [31:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_PASS_MODE: cfg_mode = mode_t'(value[1:0]);
			REG_GRID_ROWS: begin
				cfg_rows = value[7:0];
				pos_row = 0;
				pos_col = 0;
			end
			REG_GRID_COLS: begin
				cfg_cols = value[7:0];
				pos_row = 0;
				pos_col = 0;
			end
			default: cfg_thres = value;
		endcase
	endtask

	// write all registers, sometimes with junk in the unused upper bits
	task automatic apply_setting(mode_t m, logic [7:0] rows, logic [7:0] cols, logic [31:0] thr);
		logic [31:0] junk;
		junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
		cfg_write(REG_PASS_MODE, {junk[31:2], m});
		cfg_write(REG_GRID_ROWS, {junk[31:8], rows});
		cfg_write(REG_GRID_COLS, {junk[31:8], cols});
		cfg_write(REG_TREE_THRES, thr);
	endtask

	task automatic wait_for_idle();
		while (pending_cells.size() != 0 || s_tvalid || expected_next.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic queue_cells(logic [17:0] cells, int count);
		for (int k = 0; k < count; k++) pending_cells.push_back(cell_t'(cells[2 * k +: 2]));
	endtask

	function automatic cell_t pick_cell();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return CELL_EMPTY;
		if (r == 1) return CELL_ASH;
		if (r <= 3) return CELL_FIRE;
		return CELL_TREE;
	endfunction

	function automatic mode_t pick_mode();
		int r;
		r = $urandom_range(0, 9);
		if (r <= 3) return MODE_BURN;
		if (r <= 5) return MODE_IGNITE;
		if (r <= 8) return MODE_FILL;
		return MODE_HOLD;
	endfunction

	// mostly small grids, now and then out of range or the largest
	function automatic logic [7:0] pick_size();
		int r;
		r = $urandom_range(0, 39);
		if (r <= 1) return 8'($urandom_range(0, 2));
		if (r == 2) return 8'($urandom_range(129, 255));
		if (r == 3) return 8'd128;
		return 8'($urandom_range(3, 10));
	endfunction

	function automatic logic [31:0] pick_thres();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0) return 32'd0;
		if (r == 1) return 32'hFFFF_FFFF;
		if (r == 2) return THRES_RESET;
		return $urandom;
	endfunction

	// stimulus: directed grids first, then random phases of whole frames
	initial begin
		int phase, frame_cells, n, rest, sent;
		mode_t m;
		logic [7:0] nr, nc;
		logic [31:0] thr;
		logic partial;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// a few row-0 cells at reset size, then a size write restarts the frame
		queue_cells({12'd0, CELL_ASH, CELL_FIRE, CELL_TREE}, 3);
		wait_for_idle();
		cfg_write(REG_GRID_ROWS, 32'd3);
		cfg_write(REG_GRID_COLS, 32'd3);
		// burn: inner tree surrounded by fire, empty, fire and ash borders pass through
		queue_cells({CELL_EMPTY, CELL_FIRE, CELL_ASH, CELL_FIRE, CELL_TREE, CELL_FIRE,
			CELL_ASH, CELL_FIRE, CELL_EMPTY}, 9);
		wait_for_idle();
		// ignite: all trees, only the inner row-one tree catches
		cfg_write(REG_PASS_MODE, {30'd0, MODE_IGNITE});
		queue_cells(18'h15555, 9);
		wait_for_idle();

		sent = 0;
		phase = 0;
		while (sent < RANDOM_CELLS) begin
			case (phase)
				0: begin m = MODE_BURN;   nr = 8'd128; nc = 8'd3;   thr = THRES_RESET;  end
				1: begin m = MODE_FILL;   nr = 8'd3;   nc = 8'd200; thr = 32'hFFFF_FFFF; end
				2: begin m = MODE_FILL;   nr = 8'd1;   nc = 8'd0;   thr = 32'd0;        end
				3: begin m = MODE_HOLD;   nr = 8'd4;   nc = 8'd5;   thr = $urandom;     end
				4: begin m = MODE_IGNITE; nr = 8'd2;   nc = 8'd7;   thr = $urandom;     end
				default: begin
					m = pick_mode();
					nr = pick_size();
					nc = pick_size();
					thr = pick_thres();
				end
			endcase
			// keep very large grids narrow, three to five columns wide
			if (clamp_size(nr, TB_MAX_ROWS) * clamp_size(nc, TB_MAX_COLS) > 640)
				nc = 8'($urandom_range(3, 5));
			apply_setting(m, nr, nc, thr);
			tx_gaps_on = $urandom_range(0, 2) != 0;
			rx_stalls_on = $urandom_range(0, 2) != 0;

			frame_cells = clamp_size(nr, TB_MAX_ROWS) * clamp_size(nc, TB_MAX_COLS);
			n = (frame_cells > 100) ? frame_cells : frame_cells * $urandom_range(1, 3);
			partial = (phase >= 5) && ($urandom_range(0, 4) == 0);
			if (partial) n = $urandom_range(1, frame_cells - 1);
			for (int k = 0; k < n; k++) pending_cells.push_back(pick_cell());
			sent += n;
			wait_for_idle();

			// half-done frame: switch mode and finish it
			if (partial && $urandom_range(0, 1) == 0) begin
				cfg_write(REG_PASS_MODE, {30'd0, pick_mode()});
				rest = frame_cells - n;
				for (int k = 0; k < rest; k++) pending_cells.push_back(pick_cell());
				sent += rest;
				wait_for_idle();
			end
			phase++;
		end

		if (fail_count == 0) begin
			$display("forest_fire_grid_step_unit verification clean");
		end else begin
			$display("forest_fire_grid_step_unit verification failed");
		end
		$finish;
	end

	// hard stop if the unit hangs
	initial begin
		#20_000_000;
		$display("forest_fire_grid_step_unit verification failed");
		$finish;
	end

endmodule
